### hw/rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by the allocator, its checker and the testbench.
package ffba_pkg;

  localparam int unsigned ArenaBytesDef  = 65536;
  localparam int unsigned HeaderBytesDef = 32;
  localparam int unsigned MaxBlocksDef   = 64;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_NOSPACE = 2'd2,
    STATUS_BADFREE = 2'd3
  } ffba_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SHUP,
    S_SHUP_WR,
    S_SUCC,
    S_SHDN,
    S_SHDN_WR,
    S_PRED,
    S_PRED_CHK,
    S_DONE
  } ffba_state_e;

  typedef struct packed {
    logic        func;
    logic [15:0] request_size;
    logic [15:0] free_address;
  } ffba_req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
    logic [16:0] segment_bytes;
    logic [16:0] free_bytes;
  } ffba_rsp_t;

endpackage

### hw/rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator: sequencer over an address-ordered block table.
// Depends on ffba_pkg and ffba_ram.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+-----------------------
//   in      | in_valid_i | in_stall_o | in_req_i  (ffba_req_t)
//   out     | out_valid_o| out_stall_i| out_rsp_o (ffba_rsp_t)
//
// One item walks the table entries in order through the single
// registered-read table RAM (S_RD, then S_CHK per entry), and moves entries
// one by one (read, then write) when a split or merge opens or closes a slot.
// Zero-size and null requests skip the table. in_stall_o is high from
// transfer until the result is loaded into the output register.
// Reset clears the block count and totals; the table RAM needs no clearing.
// A stalled output holds; the next item may run and waits in S_DONE.
module first_fit_block_allocator
  import ffba_pkg::ffba_req_t;
  import ffba_pkg::ffba_rsp_t;
#(
  parameter int unsigned ARENA_BYTES  = ffba_pkg::ArenaBytesDef,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ffba_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ffba_rsp_t out_rsp_o
);
  import ffba_pkg::*;

  localparam int unsigned CntW = $clog2(ARENA_BYTES + 1);
  localparam int unsigned VW   = ((CntW > 16) ? CntW : 16) + 2;
  localparam int unsigned IdW  = $clog2(MAX_BLOCKS);
  localparam int unsigned NW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW   = 2 * VW + 1;

  localparam logic [VW-1:0] Hdr   = VW'(HEADER_BYTES);
  localparam logic [VW-1:0] Arena = VW'(ARENA_BYTES);
  localparam logic [NW-1:0] MaxN  = NW'(MAX_BLOCKS);
  localparam logic [NW-1:0] One   = NW'(1);

  ffba_state_e  state_q, state_d;
  logic [NW-1:0] i_q, i_d, j_q, j_d, n_q, n_d;
  logic [VW-1:0] seg_q, seg_d, free_q, free_d;
  logic          func_q, func_d;
  logic [VW-1:0] size_q, size_d, addr_q, addr_d;
  logic [VW-1:0] cur_start_q, cur_start_d, cur_len_q, cur_len_d;
  logic [VW-1:0] pay_q, pay_d;
  ffba_status_e  status_q, status_d;
  logic          pred_q, pred_d;
  logic          out_valid_q, out_valid_d;
  ffba_rsp_t     out_q, out_d;

  logic          we;
  logic [NW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          r_free;
  logic [VW-1:0] r_start, r_len, need;

  assign r_free  = rdata[EW-1];
  assign r_start = rdata[2*VW-1:VW];
  assign r_len   = rdata[VW-1:0];
  assign need    = size_q + Hdr;

  ffba_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr[IdW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr[IdW-1:0]),
    .rdata_o(rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      seg_q       <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      seg_q       <= seg_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    func_q      <= func_d;
    size_q      <= size_d;
    addr_q      <= addr_d;
    cur_start_q <= cur_start_d;
    cur_len_q   <= cur_len_d;
    pay_q       <= pay_d;
    status_q    <= status_d;
    pred_q      <= pred_d;
    out_q       <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    seg_d       = seg_q;
    free_d      = free_q;
    func_d      = func_q;
    size_d      = size_q;
    addr_d      = addr_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    pay_d       = pay_q;
    status_d    = status_q;
    pred_d      = pred_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = i_q;
    wdata       = '0;
    raddr       = i_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_req_i.func;
          size_d   = VW'(in_req_i.request_size);
          addr_d   = VW'(in_req_i.free_address);
          i_d      = '0;
          pay_d    = '0;
          status_d = STATUS_DONE;
          if ((in_req_i.func == FuncAlloc && in_req_i.request_size == '0) ||
              (in_req_i.func == FuncFree && in_req_i.free_address == '0)) begin
            status_d = STATUS_IGNORED;
            state_d  = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (i_q == n_q) begin
          state_d = S_DONE;
          if (func_q == FuncFree) begin
            status_d = STATUS_BADFREE;
          end else if (n_q == MaxN || (seg_q + need) > Arena) begin
            status_d = STATUS_NOSPACE;
          end else begin
            // grow the segment at its top
            we     = 1'b1;
            waddr  = n_q;
            wdata  = {1'b0, seg_q, size_q};
            pay_d  = seg_q + Hdr;
            seg_d  = seg_q + need;
            n_d    = n_q + One;
          end
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (func_q == FuncAlloc) begin
          if (r_free && r_len >= size_q) begin
            pay_d = r_start + Hdr;
            we    = 1'b1;
            if (r_len > need && n_q != MaxN) begin
              wdata       = {1'b0, r_start, size_q};
              cur_start_d = r_start + need;
              cur_len_d   = r_len - need;
              free_d      = free_q - need;
              j_d         = n_q;
              state_d     = S_SHUP;
            end else begin
              wdata   = {1'b0, r_start, r_len};
              free_d  = free_q - (r_len + Hdr);
              state_d = S_DONE;
            end
          end else begin
            i_d     = i_q + One;
            state_d = S_RD;
          end
        end else begin
          if (r_start + Hdr == addr_q) begin
            if (r_free) begin
              status_d = STATUS_BADFREE;
              state_d  = S_DONE;
            end else begin
              free_d      = free_q + r_len + Hdr;
              cur_start_d = r_start;
              cur_len_d   = r_len;
              pred_d      = 1'b0;
              raddr       = i_q + One;
              state_d     = (i_q + One < n_q) ? S_SUCC : S_PRED;
            end
          end else begin
            i_d     = i_q + One;
            state_d = S_RD;
          end
        end
      end
      S_SHUP: begin
        if (j_q > i_q + One) begin
          raddr   = j_q - One;
          state_d = S_SHUP_WR;
        end else begin
          we      = 1'b1;
          waddr   = i_q + One;
          wdata   = {1'b1, cur_start_q, cur_len_q};
          n_d     = n_q + One;
          state_d = S_DONE;
        end
      end
      S_SHUP_WR: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = rdata;
        j_d     = j_q - One;
        state_d = S_SHUP;
      end
      S_SUCC: begin
        if (r_free) begin
          cur_len_d = cur_len_q + Hdr + r_len;
          j_d       = i_q + One;
          state_d   = S_SHDN;
        end else begin
          state_d = S_PRED;
        end
      end
      S_SHDN: begin
        if (j_q + One < n_q) begin
          raddr   = j_q + One;
          state_d = S_SHDN_WR;
        end else begin
          n_d     = n_q - One;
          state_d = pred_q ? S_DONE : S_PRED;
        end
      end
      S_SHDN_WR: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = rdata;
        j_d     = j_q + One;
        state_d = S_SHDN;
      end
      S_PRED: begin
        if (i_q != '0) begin
          raddr   = i_q - One;
          state_d = S_PRED_CHK;
        end else begin
          we      = 1'b1;
          wdata   = {1'b1, cur_start_q, cur_len_q};
          state_d = S_DONE;
        end
      end
      S_PRED_CHK: begin
        we = 1'b1;
        if (r_free) begin
          // fold into predecessor, then drop entry i
          waddr   = i_q - One;
          wdata   = {1'b1, r_start, r_len + Hdr + cur_len_q};
          j_d     = i_q;
          pred_d  = 1'b1;
          state_d = S_SHDN;
        end else begin
          wdata   = {1'b1, cur_start_q, cur_len_q};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.payload_address = pay_q[15:0];
          out_d.status          = status_q;
          out_d.segment_bytes   = seg_q[16:0];
          out_d.free_bytes      = free_q[16:0];
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ffba_checker.sv
// Port-level checks for the first-fit block allocator, bound to the top.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker
  import ffba_pkg::ffba_req_t;
  import ffba_pkg::ffba_rsp_t;
#(
  parameter int unsigned ARENA_BYTES = ffba_pkg::ArenaBytesDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ffba_req_t in_req_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ffba_rsp_t out_rsp_o
);
  import ffba_pkg::*;

  localparam logic [17:0] Arena = 18'(ARENA_BYTES);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != STATUS_DONE |-> out_rsp_o.payload_address == '0)
    else $error("address granted on failed request");

  a_free_le_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.free_bytes <= out_rsp_o.segment_bytes)
    else $error("free bytes exceed segment");

  a_seg_le_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_rsp_o.segment_bytes} <= Arena)
    else $error("segment exceeds arena");

endmodule

bind first_fit_block_allocator ffba_checker #(
  .ARENA_BYTES(ARENA_BYTES)
) u_ffba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_o  (out_rsp_o)
);

### tb/first_fit_block_allocator_tb.sv
// Self-checking testbench for first_fit_block_allocator: directed table, then random traffic.
// Depends on ffba_pkg and the block's RTL. A predictor of the block table checks every result.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int unsigned Arena  = 65536;
  localparam int unsigned Header = 32;
  localparam int unsigned Blocks = 64;
  localparam int RandItems   = 650;
  localparam int FillStart   = 200;
  localparam int FillLen     = 70;
  localparam int HoldAt      = 300;
  localparam int DrainAt     = 420;
  localparam int QuietAt     = 560;
  localparam int HoldCycles  = 400;

  typedef struct {
    logic        func;
    logic [15:0] size;
    logic [15:0] addr;
    bit          typed;
    ffba_rsp_t   rsp;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  ffba_req_t in_req_i;
  logic      out_valid_o;
  logic      out_stall_i;
  ffba_rsp_t out_rsp_o;

  // block table mirror
  int unsigned blk_start [Blocks];
  int unsigned blk_len   [Blocks];
  bit          blk_free  [Blocks];
  int unsigned blk_cnt;
  int unsigned seg_total;
  int unsigned free_total;

  ffba_rsp_t   rsp_q [$];
  int unsigned live_q [$];
  int unsigned freed_q [$];
  dir_row_t    dir_tbl [$];
  int          errors;
  bit          quiet;
  bit          hold_req;

  first_fit_block_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_entry(int unsigned p);
    for (int unsigned j = p; j + 1 < blk_cnt; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_len[j]   = blk_len[j+1];
      blk_free[j]  = blk_free[j+1];
    end
    blk_cnt--;
  endfunction

  function automatic ffba_rsp_t alloc_grant(int unsigned size);
    ffba_rsp_t   r;
    int unsigned need;
    need = size + Header;
    r = '0;
    r.status = STATUS_DONE;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (blk_free[i] && blk_len[i] >= size) begin
        if (blk_len[i] > need && blk_cnt < Blocks) begin
          for (int unsigned j = blk_cnt; j > i + 1; j--) begin
            blk_start[j] = blk_start[j-1];
            blk_len[j]   = blk_len[j-1];
            blk_free[j]  = blk_free[j-1];
          end
          blk_start[i+1] = blk_start[i] + need;
          blk_len[i+1]   = blk_len[i] - need;
          blk_free[i+1]  = 1'b1;
          blk_len[i]     = size;
          blk_cnt++;
          free_total -= need;
        end else begin
          free_total -= blk_len[i] + Header;
        end
        blk_free[i] = 1'b0;
        r.payload_address = 16'(blk_start[i] + Header);
        return r;
      end
    end
    if (blk_cnt >= Blocks || seg_total + need > Arena) begin
      r.status = STATUS_NOSPACE;
      return r;
    end
    blk_start[blk_cnt] = seg_total;
    blk_len[blk_cnt]   = size;
    blk_free[blk_cnt]  = 1'b0;
    blk_cnt++;
    seg_total += need;
    r.payload_address = 16'(seg_total - size);
    return r;
  endfunction

  function automatic ffba_status_e release_block(int unsigned addr);
    int unsigned i;
    for (i = 0; i < blk_cnt; i++)
      if (blk_start[i] + Header == addr) break;
    if (i >= blk_cnt || blk_free[i]) return STATUS_BADFREE;
    blk_free[i] = 1'b1;
    free_total += blk_len[i] + Header;
    if (i + 1 < blk_cnt && blk_free[i+1]) begin
      blk_len[i] += Header + blk_len[i+1];
      drop_entry(i + 1);
    end
    if (i > 0 && blk_free[i-1]) begin
      blk_len[i-1] += Header + blk_len[i];
      drop_entry(i);
    end
    return STATUS_DONE;
  endfunction

  function automatic ffba_rsp_t predict_alloc(ffba_req_t req);
    ffba_rsp_t r;
    r = '0;
    if (req.func == FuncAlloc) begin
      if (req.request_size == 0) r.status = STATUS_IGNORED;
      else r = alloc_grant(req.request_size);
    end else begin
      if (req.free_address == 0) r.status = STATUS_IGNORED;
      else r.status = release_block(req.free_address);
    end
    r.segment_bytes = 17'(seg_total);
    r.free_bytes    = 17'(free_total);
    return r;
  endfunction

  // Predict, queue the expectation, and keep the pool of live addresses current.
  task automatic note_transfer(ffba_req_t req, bit typed, ffba_rsp_t typed_rsp);
    ffba_rsp_t r;
    int        idx[$];
    r = predict_alloc(req);
    rsp_q.push_back(typed ? typed_rsp : r);
    if (r.status == STATUS_DONE) begin
      if (req.func == FuncAlloc) begin
        live_q.push_back(r.payload_address);
      end else begin
        idx = live_q.find_first_index(a) with (a == req.free_address);
        if (idx.size() > 0) live_q.delete(idx[0]);
        freed_q.push_back(req.free_address);
        if (freed_q.size() > 16) void'(freed_q.pop_front());
      end
    end
  endtask

  task automatic send_item(ffba_req_t req, bit typed, ffba_rsp_t typed_rsp);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(14, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    note_transfer(req, typed, typed_rsp);
  endtask

  function automatic ffba_req_t rand_item();
    ffba_req_t   req;
    int unsigned pick;
    req.func         = FuncAlloc;
    req.request_size = 16'($urandom);
    req.free_address = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 45 || (pick < 85 && live_q.size() == 0)) begin
      pick = $urandom_range(99);
      if (pick < 70)      req.request_size = 16'($urandom_range(256, 1));
      else if (pick < 90) req.request_size = 16'($urandom_range(4096, 257));
      else if (pick < 98) req.request_size = 16'($urandom_range(32768, 4097));
      else                req.request_size = 16'($urandom_range(65535, 32769));
    end else if (pick < 85) begin
      req.func         = FuncFree;
      req.free_address = 16'(live_q[$urandom_range(live_q.size() - 1)]);
    end else begin
      // noise: zero size, null, unknown or repeated release
      case ($urandom_range(3))
        0: req.request_size = '0;
        1: begin
          req.func = FuncFree;
          req.free_address = '0;
        end
        2: req.func = FuncFree;
        default: begin
          req.func = FuncFree;
          if (freed_q.size() > 0)
            req.free_address = 16'(freed_q[$urandom_range(freed_q.size() - 1)]);
        end
      endcase
    end
    return req;
  endfunction

  // Result check
  always @(posedge clk_i) begin
    ffba_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_rsp_o);
        errors++;
      end else begin
        exp_rsp = rsp_q.pop_front();
        if (out_rsp_o.payload_address !== exp_rsp.payload_address) begin
          $display("%0t: payload_address expected %0d actual %0d", $time,
                   exp_rsp.payload_address, out_rsp_o.payload_address);
          errors++;
        end
        if (out_rsp_o.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_rsp.status, out_rsp_o.status);
          errors++;
        end
        if (out_rsp_o.segment_bytes !== exp_rsp.segment_bytes) begin
          $display("%0t: segment_bytes expected %0d actual %0d", $time,
                   exp_rsp.segment_bytes, out_rsp_o.segment_bytes);
          errors++;
        end
        if (out_rsp_o.free_bytes !== exp_rsp.free_bytes) begin
          $display("%0t: free_bytes expected %0d actual %0d", $time,
                   exp_rsp.free_bytes, out_rsp_o.free_bytes);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random bursts, one long hold on request, none when quiet
  initial begin
    int burst;
    int hold;
    out_stall_i <= 1'b0;
    burst = 0;
    hold  = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold = HoldCycles;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(5) == 0) begin
        burst = $urandom_range(13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("first_fit_block_allocator test failed");
    $finish;
  end

  initial begin
    ffba_req_t req;
    dir_row_t  row;
    int        waited;
    errors   = 0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    blk_cnt    = 0;
    seg_total  = 0;
    free_total = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;

    //                func      size    addr     typed  payload status          segment free
    dir_tbl = '{
      '{FuncAlloc, 16'd0,     16'hFFFF, 1'b1, '{16'd0,  STATUS_IGNORED, 17'd0,     17'd0}},
      '{FuncFree,  16'hFFFF,  16'd0,    1'b1, '{16'd0,  STATUS_IGNORED, 17'd0,     17'd0}},
      '{FuncFree,  16'd0,     16'hFFFF, 1'b1, '{16'd0,  STATUS_BADFREE, 17'd0,     17'd0}},
      '{FuncFree,  16'd0,     16'd32,   1'b1, '{16'd0,  STATUS_BADFREE, 17'd0,     17'd0}},
      '{FuncAlloc, 16'd65504, 16'd0,    1'b1, '{16'd32, STATUS_DONE,    17'd65536, 17'd0}},
      '{FuncAlloc, 16'd1,     16'd0,    1'b1, '{16'd0,  STATUS_NOSPACE, 17'd65536, 17'd0}},
      '{FuncAlloc, 16'hFFFF,  16'd0,    1'b1, '{16'd0,  STATUS_NOSPACE, 17'd65536, 17'd0}},
      '{FuncFree,  16'd0,     16'd33,   1'b1, '{16'd0,  STATUS_BADFREE, 17'd65536, 17'd0}},
      '{FuncFree,  16'd0,     16'd32,   1'b1, '{16'd0,  STATUS_DONE,    17'd65536, 17'd65536}},
      '{FuncFree,  16'd0,     16'd32,   1'b1, '{16'd0,  STATUS_BADFREE, 17'd65536, 17'd65536}},
      '{FuncAlloc, 16'd16,    16'd0,    1'b1, '{16'd32, STATUS_DONE,    17'd65536, 17'd65488}},
      '{FuncAlloc, 16'd65456, 16'd0,    1'b1, '{16'd80, STATUS_DONE,    17'd65536, 17'd0}},
      '{FuncFree,  16'd0,     16'd32,   1'b1, '{16'd0,  STATUS_DONE,    17'd65536, 17'd48}},
      '{FuncFree,  16'd0,     16'd80,   1'b1, '{16'd0,  STATUS_DONE,    17'd65536, 17'd65536}},
      '{FuncAlloc, 16'd100,   16'd0,    1'b0, '0},
      '{FuncAlloc, 16'd200,   16'd0,    1'b0, '0},
      '{FuncAlloc, 16'd300,   16'd0,    1'b0, '0},
      '{FuncFree,  16'd0,     16'd164,  1'b0, '0},
      '{FuncFree,  16'd0,     16'd32,   1'b0, '0},
      '{FuncAlloc, 16'd64,    16'd0,    1'b0, '0},
      '{FuncFree,  16'd0,     16'd396,  1'b0, '0},
      '{FuncFree,  16'd0,     16'd32,   1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[k]) begin
      row = dir_tbl[k];
      req.func         = row.func;
      req.request_size = row.size;
      req.free_address = row.addr;
      send_item(req, row.typed, row.rsp);
    end

    for (int k = 0; k < RandItems; k++) begin
      if (k == HoldAt) hold_req = 1'b1;
      if (k == QuietAt) quiet = 1'b1;
      if (k == DrainAt) begin
        in_valid_i <= 1'b0;
        while (rsp_q.size() > 0) @(posedge clk_i);
      end
      if (k >= FillStart && k < FillStart + FillLen) begin
        // run of small grants to push the table to its limit
        req.func         = FuncAlloc;
        req.request_size = 16'($urandom_range(48, 1));
        req.free_address = 16'($urandom);
      end else begin
        req = rand_item();
      end
      send_item(req, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (rsp_q.size() > 0 && waited < 100_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);

    if (errors == 0 && rsp_q.size() == 0) begin
      $display("first_fit_block_allocator test passed");
    end else begin
      if (rsp_q.size() > 0)
        $display("%0t: %0d results never arrived", $time, rsp_q.size());
      $display("first_fit_block_allocator test failed");
    end
    $finish;
  end

endmodule
